// File: sv/assert_macros.svh
// Assertion helpers shared by the block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define JSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jse assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define JSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jse assertion failed");

`endif

// File: sv/jse_pkg.sv
package jse_pkg;

    localparam int MaxRun = 6;

    localparam logic [1:0] REQ_OPEN  = 2'd0;
    localparam logic [1:0] REQ_DATA  = 2'd1;
    localparam logic [1:0] REQ_CLOSE = 2'd2;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_LOWA  = 8'h61;

    localparam logic [7:0] CTRL_BS  = 8'h08;
    localparam logic [7:0] CTRL_TAB = 8'h09;
    localparam logic [7:0] CTRL_LF  = 8'h0a;
    localparam logic [7:0] CTRL_FF  = 8'h0c;
    localparam logic [7:0] CTRL_CR  = 8'h0d;
    localparam logic [7:0] CTRL_END = 8'h20;

    localparam logic [20:0] CP_MIN3    = 21'h000800;
    localparam logic [20:0] CP_SUR_LO  = 21'h00d800;
    localparam logic [20:0] CP_SUR_HI  = 21'h00dfff;
    localparam logic [20:0] CP_MIN4    = 21'h010000;
    localparam logic [20:0] CP_MAX     = 21'h10ffff;

    typedef logic [MaxRun-1:0][7:0] t_run_bytes;

    // One request's worth of output: bytes go out from index 0 upward.
    typedef struct packed {
        t_run_bytes bytes;
        logic [2:0] len;
        logic       fail;
    } t_run;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = CH_ZERO + {4'd0, nib};
        end else begin
            r = CH_LOWA + {4'd0, nib} - 8'd10;
        end
        return r;
    endfunction

endpackage

// File: sv/jse_ifs.sv
interface jse_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface jse_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       failed;

    modport source (output valid, output out_byte, output run_last, output failed,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input failed,
                    output ready);
endinterface

// File: sv/jse_core.sv
`include "assert_macros.svh"

module jse_core
    import jse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_data_byte,
    output t_run       o_run
);

    logic [7:0]  r_held [3];
    logic [2:0]  r_need;
    logic [1:0]  r_cnt;
    logic [20:0] r_acc;
    logic        r_fail;

    logic [2:0]  n_need;
    logic [1:0]  n_cnt;
    logic [20:0] n_acc;
    logic        n_fail;
    logic        held_we;
    logic [1:0]  held_idx;
    logic [20:0] acc_ext;
    t_run        run;

    assign acc_ext = {r_acc[14:0], i_data_byte[5:0]};

    always_comb begin
        n_need   = r_need;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_fail   = r_fail;
        held_we  = 1'b0;
        held_idx = r_cnt;
        run      = '0;
        case (i_req_type)
            REQ_OPEN: begin
                n_fail = 1'b0;
                n_need = '0;
                n_cnt  = '0;
                n_acc  = '0;
                run.bytes[0] = CH_QUOTE;
                run.len = 3'd1;
            end
            REQ_DATA: begin
                if (!r_fail) begin
                    if (r_need != 3'd0) begin
                        if (i_data_byte[7:6] != 2'b10 || r_cnt == 2'd0) begin
                            run.fail = 1'b1;
                        end else if ({1'b0, r_cnt} + 3'd1 < r_need) begin
                            n_acc   = acc_ext;
                            held_we = 1'b1;
                            n_cnt   = r_cnt + 2'd1;
                        end else if ((r_need == 3'd3 && (acc_ext < CP_MIN3 ||
                                     (acc_ext >= CP_SUR_LO && acc_ext <= CP_SUR_HI))) ||
                                     (r_need == 3'd4 && (acc_ext < CP_MIN4 ||
                                     acc_ext > CP_MAX))) begin
                            run.fail = 1'b1;
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                if (3'(i) < {1'b0, r_cnt}) begin
                                    run.bytes[i] = r_held[i];
                                end
                            end
                            run.bytes[{1'b0, r_cnt}] = i_data_byte;
                            run.len = {1'b0, r_cnt} + 3'd1;
                            n_need = '0;
                            n_cnt  = '0;
                            n_acc  = '0;
                        end
                    end else begin
                        case (i_data_byte)
                            CH_QUOTE, CH_BSL: begin
                                run.bytes[0] = CH_BSL;
                                run.bytes[1] = i_data_byte;
                                run.len = 3'd2;
                            end
                            CTRL_BS:  begin run.bytes[0] = CH_BSL; run.bytes[1] = CH_B;
                                            run.len = 3'd2; end
                            CTRL_FF:  begin run.bytes[0] = CH_BSL; run.bytes[1] = CH_F;
                                            run.len = 3'd2; end
                            CTRL_LF:  begin run.bytes[0] = CH_BSL; run.bytes[1] = CH_N;
                                            run.len = 3'd2; end
                            CTRL_CR:  begin run.bytes[0] = CH_BSL; run.bytes[1] = CH_R;
                                            run.len = 3'd2; end
                            CTRL_TAB: begin run.bytes[0] = CH_BSL; run.bytes[1] = CH_T;
                                            run.len = 3'd2; end
                            default: begin
                                if (i_data_byte < CTRL_END) begin
                                    run.bytes[0] = CH_BSL;
                                    run.bytes[1] = CH_U;
                                    run.bytes[2] = CH_ZERO;
                                    run.bytes[3] = CH_ZERO;
                                    run.bytes[4] = hex_char(i_data_byte[7:4]);
                                    run.bytes[5] = hex_char(i_data_byte[3:0]);
                                    run.len = 3'd6;
                                end else if (!i_data_byte[7]) begin
                                    run.bytes[0] = i_data_byte;
                                    run.len = 3'd1;
                                end else if (i_data_byte inside {[8'hc2:8'hdf]}) begin
                                    n_need = 3'd2;
                                    n_acc = {16'd0, i_data_byte[4:0]};
                                end else if (i_data_byte inside {[8'he0:8'hef]}) begin
                                    n_need = 3'd3;
                                    n_acc = {17'd0, i_data_byte[3:0]};
                                end else if (i_data_byte inside {[8'hf0:8'hf4]}) begin
                                    n_need = 3'd4;
                                    n_acc = {18'd0, i_data_byte[2:0]};
                                end else begin
                                    run.fail = 1'b1;
                                end
                                // A lead byte is kept as the first held byte.
                                if (n_need != 3'd0) begin
                                    held_we  = 1'b1;
                                    held_idx = 2'd0;
                                    n_cnt    = 2'd1;
                                end
                            end
                        endcase
                    end
                end
            end
            REQ_CLOSE: begin
                if (!r_fail) begin
                    if (r_need != 3'd0) begin
                        run.fail = 1'b1;
                    end else begin
                        run.bytes[0] = CH_QUOTE;
                        run.len = 3'd1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (run.fail) begin
            run.bytes = '0;
            run.len   = 3'd1;
            n_need    = '0;
            n_cnt     = '0;
            n_acc     = '0;
            n_fail    = 1'b1;
            held_we   = 1'b0;
        end
    end

    assign o_run = run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need <= '0;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_fail <= 1'b0;
        end else if (i_fire) begin
            r_need <= n_need;
            r_cnt  <= n_cnt;
            r_acc  <= n_acc;
            r_fail <= n_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && held_we) begin
            r_held[held_idx] <= i_data_byte;
        end
    end

    `JSE_ASSERT_NOW(a_fail_no_pending, i_clk, i_rst_n, r_fail, r_need == 3'd0)
    `JSE_ASSERT_NOW(a_pending_count, i_clk, i_rst_n, r_need != 3'd0,
        r_cnt != 2'd0 && {1'b0, r_cnt} < r_need && r_need >= 3'd2)
    `JSE_ASSERT_NOW(a_idle_count, i_clk, i_rst_n, r_need == 3'd0, r_cnt == 2'd0)

endmodule

// File: sv/jse_emit.sv
`include "assert_macros.svh"

module jse_emit
    import jse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_run       i_run,
    output logic       o_can_load,
    jse_res_if.source  o_res
);

    t_run_bytes r_bytes;
    logic [2:0] r_left;
    logic       r_fail;
    logic       pop;

    assign pop        = (r_left != 3'd0) && o_res.ready;
    assign o_can_load = (r_left == 3'd0) || (r_left == 3'd1 && o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= i_run.len;
        end else if (pop) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_run.bytes;
            r_fail  <= i_run.fail;
        end else if (pop) begin
            r_bytes <= r_bytes >> 8;
        end
    end

    assign o_res.valid    = r_left != 3'd0;
    assign o_res.out_byte = r_bytes[0];
    assign o_res.run_last = r_left == 3'd1;
    assign o_res.failed   = r_fail;

    `JSE_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, i_load, o_can_load)
    `JSE_ASSERT_NOW(a_left_bound, i_clk, i_rst_n, 1'b1, r_left <= 3'(MaxRun))
    `JSE_ASSERT_NOW(a_fail_single, i_clk, i_rst_n, o_res.valid && o_res.failed,
        o_res.run_last && o_res.out_byte == 8'd0)

endmodule

// File: sv/json_string_escaper_unit.sv
// Channel   Direction  Payload
// i_req     in         req_type[1:0], data_byte[7:0]
// o_res     out        out_byte[7:0], run_last, failed
//
// A request waits in the input register until the output shift register can take
// its run; then the whole run is decoded and loaded into it in one step.
// Result bytes leave one at a time, byte 0 first, while o_res is ready; requests
// with no result (held UTF-8 bytes, blocked input) load an empty run.
// The output shift register sets the rate: a new run loads as its last byte leaves.
// i_rst_n is synchronous; it clears the UTF-8 state, the failure latch and both
// valid flags. A stall on o_res holds the run and backs up into i_req.
module json_string_escaper_unit
    import jse_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    jse_req_if.sink   i_req,
    jse_res_if.source o_res
);

    logic       r_in_valid;
    logic [1:0] r_req_type;
    logic [7:0] r_data_byte;
    logic       can_load;
    logic       load;
    t_run       run;

    assign load        = r_in_valid && can_load;
    assign i_req.ready = !r_in_valid || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req_type  <= i_req.req_type;
            r_data_byte <= i_req.data_byte;
        end
    end

    jse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (load),
        .i_req_type  (r_req_type),
        .i_data_byte (r_data_byte),
        .o_run       (run)
    );

    jse_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_run      (run),
        .o_can_load (can_load),
        .o_res      (o_res)
    );

endmodule
